FILE: hdl/vn_pkg.sv
// shared constants and types for the vector normaliser
package vn_pkg;
  localparam int LANES      = 4;
  localparam int Q_BITS     = 16;
  localparam int FRAC_SHIFT = 30;
  localparam int GUARD_BITS = 34;
  typedef logic [Q_BITS-1:0] unit_t;
  localparam unit_t Q_MAX_POS = 16'h7fff;
endpackage

FILE: hdl/vector4_normalizer_core.sv
// top level of the 4-component vector normaliser
// Takes one vector per transaction on in_valid/in_ready (four signed components
// of COMPONENT_WIDTH bits) and returns one transaction on out_valid/out_ready:
// four signed Q1.15 unit components, each truncated toward zero, with +1.0
// saturated to 32767, and a zero_length flag for the all-zero vector (units 0).
// The path from the accepting edge to out_valid runs through twenty register
// stages (three front stages for magnitude, square and sum, sixteen
// quotient-bit cells in a row, one output register), the first loaded at the
// accepting edge. Throughput is one vector per cycle while the output is not
// stalled; each cell tests one quotient bit with shifts and adds only, so the
// wide add and compare inside a cell sets the cycle time.
// The whole pipeline moves together: when the receiver stalls a held result,
// every stage holds and in_ready drops until the result is taken; bubbles
// in the pipe are not filled meanwhile; they move only as the output moves.
// Synchronous active-low reset clears all stage valid flags; no result is
// presented until a vector has passed all stages.
module vector4_normalizer_core #(
  parameter int COMPONENT_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COMPONENT_WIDTH-1:0] in_comp_x,
  input  logic signed [COMPONENT_WIDTH-1:0] in_comp_y,
  input  logic signed [COMPONENT_WIDTH-1:0] in_comp_z,
  input  logic signed [COMPONENT_WIDTH-1:0] in_comp_w,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [15:0]                out_unit_x,
  output logic signed [15:0]                out_unit_y,
  output logic signed [15:0]                out_unit_z,
  output logic signed [15:0]                out_unit_w,
  output logic                              out_zero_length
);
  localparam int W  = COMPONENT_WIDTH;
  localparam int PW = 2*W+vn_pkg::GUARD_BITS;
  localparam int LN = vn_pkg::LANES;
  localparam int QB = vn_pkg::Q_BITS;

  logic                      adv;
  logic [LN-1:0][W-1:0]      comp;
  logic                      v_c [0:QB];
  logic                      z_c [0:QB];
  logic [LN-1:0]             n_c [0:QB];
  logic [PW-1:0]             s_c [0:QB];
  logic [LN-1:0][PW-1:0]     t_c [0:QB];
  logic [LN-1:0][PW-1:0]     p_c [0:QB];
  logic [LN-1:0][PW-1:0]     r_c [0:QB];
  logic [LN-1:0][QB-1:0]     q_c [0:QB];
  vn_pkg::unit_t             unit_nxt [LN];
  vn_pkg::unit_t             unit_r [LN];
  logic                      out_valid_r, zero_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign comp     = {in_comp_w, in_comp_z, in_comp_y, in_comp_x};

  vn_front #(.W(W)) u_front (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(in_valid), .comp(comp),
    .valid_o(v_c[0]), .zero_o(z_c[0]), .neg_o(n_c[0]), .s_o(s_c[0]), .t_o(t_c[0])
  );
  assign p_c[0] = '0;
  assign r_c[0] = '0;
  assign q_c[0] = '0;

  for (genvar i = 0; i < QB; i++) begin : g_cell
    vn_cell #(.W(W), .BIT(QB-1-i)) u_cell (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .valid_i(v_c[i]), .zero_i(z_c[i]), .neg_i(n_c[i]), .s_i(s_c[i]),
      .t_i(t_c[i]), .p_i(p_c[i]), .r_i(r_c[i]), .q_i(q_c[i]),
      .valid_r(v_c[i+1]), .zero_r(z_c[i+1]), .neg_r(n_c[i+1]), .s_r(s_c[i+1]),
      .t_r(t_c[i+1]), .p_r(p_c[i+1]), .r_r(r_c[i+1]), .q_r(q_c[i+1])
    );
  end

  always_comb begin
    for (int l = 0; l < LN; l++) begin
      if (z_c[QB]) begin
        unit_nxt[l] = '0;
      end else if (n_c[QB][l]) begin
        unit_nxt[l] = ~q_c[QB][l] + QB'(1);
      end else if (q_c[QB][l] > vn_pkg::Q_MAX_POS) begin
        unit_nxt[l] = vn_pkg::Q_MAX_POS;
      end else begin
        unit_nxt[l] = q_c[QB][l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_c[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      unit_r <= unit_nxt;
      zero_r <= z_c[QB];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_unit_x      = unit_r[0];
  assign out_unit_y      = unit_r[1];
  assign out_unit_z      = unit_r[2];
  assign out_unit_w      = unit_r[3];
  assign out_zero_length = zero_r;

  a_zero_units: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_length |->
      out_unit_x == '0 && out_unit_y == '0 && out_unit_z == '0 && out_unit_w == '0)
    else $error("zero length result with nonzero components");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(v_c[QB]) && $stable(q_c[QB]))
    else $error("pipeline moved while output stalled");
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !v_c[0])
    else $error("valid flag set straight after reset");
endmodule

FILE: hdl/vn_front.sv
// front end: magnitudes, squares, sum of squares and per-lane targets
module vn_front #(
  parameter int W = 16
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            adv,
  input  logic                                            in_valid,
  input  logic [vn_pkg::LANES-1:0][W-1:0]                 comp,
  output logic                                            valid_o,
  output logic                                            zero_o,
  output logic [vn_pkg::LANES-1:0]                        neg_o,
  output logic [2*W+vn_pkg::GUARD_BITS-1:0]               s_o,
  output logic [vn_pkg::LANES-1:0][2*W+vn_pkg::GUARD_BITS-1:0] t_o
);
  localparam int PW = 2*W+vn_pkg::GUARD_BITS;
  localparam int LN = vn_pkg::LANES;

  logic                   va_r, vb_r, vc_r;
  logic [LN-1:0]          nega_r, negb_r, negc_r;
  logic [LN-1:0][W-1:0]   mag_r, mag_nxt;
  logic [LN-1:0][2*W-1:0] sq_r;
  logic [PW-1:0]          s_r, s_nxt;
  logic [LN-1:0][PW-1:0]  t_r;

  always_comb begin
    s_nxt = '0;
    for (int l = 0; l < LN; l++) begin
      mag_nxt[l] = comp[l][W-1] ? (~comp[l] + W'(1)) : comp[l];
      s_nxt      = s_nxt + PW'(sq_r[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < LN; l++) begin
        nega_r[l] <= comp[l][W-1];
        mag_r[l]  <= mag_nxt[l];
        sq_r[l]   <= mag_r[l] * mag_r[l];
        t_r[l]    <= PW'(sq_r[l]) << vn_pkg::FRAC_SHIFT;
      end
      negb_r <= nega_r;
      negc_r <= negb_r;
      s_r    <= s_nxt;
    end
  end

  assign valid_o = vc_r;
  assign zero_o  = (s_r == '0);
  assign neg_o   = negc_r;
  assign s_o     = s_r;
  assign t_o     = t_r;
endmodule

FILE: hdl/vn_cell.sv
// one quotient bit cell: trial of a single bit for all four lanes
module vn_cell #(
  parameter int W   = 16,
  parameter int BIT = 15
) (
  input  logic                                                  clk,
  input  logic                                                  rst_n,
  input  logic                                                  adv,
  input  logic                                                  valid_i,
  input  logic                                                  zero_i,
  input  logic [vn_pkg::LANES-1:0]                              neg_i,
  input  logic [2*W+vn_pkg::GUARD_BITS-1:0]                     s_i,
  input  logic [vn_pkg::LANES-1:0][2*W+vn_pkg::GUARD_BITS-1:0]  t_i,
  input  logic [vn_pkg::LANES-1:0][2*W+vn_pkg::GUARD_BITS-1:0]  p_i,
  input  logic [vn_pkg::LANES-1:0][2*W+vn_pkg::GUARD_BITS-1:0]  r_i,
  input  logic [vn_pkg::LANES-1:0][vn_pkg::Q_BITS-1:0]          q_i,
  output logic                                                  valid_r,
  output logic                                                  zero_r,
  output logic [vn_pkg::LANES-1:0]                              neg_r,
  output logic [2*W+vn_pkg::GUARD_BITS-1:0]                     s_r,
  output logic [vn_pkg::LANES-1:0][2*W+vn_pkg::GUARD_BITS-1:0]  t_r,
  output logic [vn_pkg::LANES-1:0][2*W+vn_pkg::GUARD_BITS-1:0]  p_r,
  output logic [vn_pkg::LANES-1:0][2*W+vn_pkg::GUARD_BITS-1:0]  r_r,
  output logic [vn_pkg::LANES-1:0][vn_pkg::Q_BITS-1:0]          q_r
);
  localparam int PW = 2*W+vn_pkg::GUARD_BITS;
  localparam int LN = vn_pkg::LANES;

  logic [LN-1:0][PW-1:0]              trial, p_nxt, r_nxt;
  logic [LN-1:0][vn_pkg::Q_BITS-1:0]  q_nxt;
  logic [LN-1:0]                      take;

  // (q + 2^k)^2 s = q^2 s + 2^(k+1) q s + 2^(2k) s
  always_comb begin
    for (int l = 0; l < LN; l++) begin
      trial[l] = p_i[l] + (r_i[l] << (BIT+1)) + (s_i << (2*BIT));
      take[l]  = (trial[l] <= t_i[l]);
      p_nxt[l] = take[l] ? trial[l] : p_i[l];
      r_nxt[l] = take[l] ? (r_i[l] + (s_i << BIT)) : r_i[l];
      q_nxt[l] = q_i[l] | (vn_pkg::Q_BITS'(take[l]) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zero_r <= zero_i;
      neg_r  <= neg_i;
      s_r    <= s_i;
      t_r    <= t_i;
      p_r    <= p_nxt;
      r_r    <= r_nxt;
      q_r    <= q_nxt;
    end
  end
endmodule
